>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the task file core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, clocked on clk, quiet during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> sv/atapio_pkg.sv
// ---------------------------------------------------------------------------
// atapio_pkg
// Types, codes and constants shared by the ATA PIO task file core.
// ---------------------------------------------------------------------------
package atapio_pkg;

  // Sizing
  localparam int MAX_SECTORS_DEF  = 64;
  localparam int WORDS_PER_SECTOR = 256;
  localparam int WORD_IDX_W       = 8;
  localparam int LBA_W            = 28;
  localparam int CAP_W            = 7;

  // Configuration register indexes and reset values
  localparam logic CFG_MASK = 1'b0;
  localparam logic CFG_CAP  = 1'b1;
  localparam logic [1:0]       MASK_RESET = 2'd1;
  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;

  // Task file offsets
  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_ERROR  = 3'd1;
  localparam logic [2:0] OFF_COUNT  = 3'd2;
  localparam logic [2:0] OFF_LBA_LO = 3'd3;
  localparam logic [2:0] OFF_LBA_MI = 3'd4;
  localparam logic [2:0] OFF_LBA_HI = 3'd5;
  localparam logic [2:0] OFF_SELECT = 3'd6;
  localparam logic [2:0] OFF_STATUS = 3'd7;

  // Commands
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_FLUSH    = 8'hE7;

  // Status bits and error codes
  localparam logic [7:0] ST_DRQ    = 8'h08;
  localparam logic [7:0] ST_ERR    = 8'h01;
  localparam logic [7:0] ERR_ABORT = 8'h04;
  localparam logic [7:0] ERR_RANGE = 8'h10;

  // Register reset values
  localparam logic [7:0] COUNT_RESET  = 8'h01;
  localparam logic [7:0] SELECT_RESET = 8'hA0;

  // Identify page
  localparam logic [WORD_IDX_W-1:0] ID_TEXT_FIRST = 8'd27;
  localparam logic [WORD_IDX_W-1:0] ID_TEXT_LAST  = 8'd46;
  localparam logic [WORD_IDX_W-1:0] ID_CAP_WORD   = 8'd60;
  localparam logic [15:0]           ID_SPACES     = 16'h2020;

  // Transfer state
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_IDENT = 4'b0010,
    MODE_READ  = 4'b0100,
    MODE_WRITE = 4'b1000
  } mode_t;

  // Sector store port control
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

  // Response capture: where the word comes from and the register value
  typedef struct packed {
    logic        from_mem;
    logic [15:0] value;
  } rsp_t;

endpackage

>>> sv/atapio_cfg.sv
// ---------------------------------------------------------------------------
// atapio_cfg
// APB configuration registers: drive presence mask and disk capacity.
// ---------------------------------------------------------------------------
module atapio_cfg import atapio_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       drive_mask,
  output logic [CAP_W-1:0] disk_cap
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write on the access phase, decoded on the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mask <= MASK_RESET;
      disk_cap   <= CAP_RESET;
    end else if (wr_en) begin
      if (paddr[2] == CFG_MASK) begin
        drive_mask <= pwdata[1:0];
      end else begin
        disk_cap <= pwdata[CAP_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_CAP) begin
      prdata[CAP_W-1:0] = disk_cap;
    end else begin
      prdata[1:0] = drive_mask;
    end
  end

endmodule

>>> sv/atapio_store.sv
// ---------------------------------------------------------------------------
// atapio_store
// Sector store for both drives: one port, registered read data.
// ---------------------------------------------------------------------------
module atapio_store import atapio_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  localparam int DEPTH  = 2 * MAX_SECTORS * WORDS_PER_SECTOR,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  mem_ctrl_t         ctrl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [15:0]       wdata,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  // Write or read one word per transaction; hold read data otherwise
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[addr] <= wdata;
    end
    if (ctrl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/atapio_tfile.sv
// ---------------------------------------------------------------------------
// atapio_tfile
// Task file registers, command decode and PIO transfer sequencing.
// ---------------------------------------------------------------------------
module atapio_tfile import atapio_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  localparam int SIDX_W = $clog2(2 * MAX_SECTORS),
  localparam int ADDR_W = SIDX_W + WORD_IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              req_type,
  input  logic [2:0]        reg_offset,
  input  logic [15:0]       wdata,
  input  logic [1:0]        drive_mask,
  input  logic [CAP_W-1:0]  disk_cap,
  output mem_ctrl_t         mem_ctrl,
  output logic [ADDR_W-1:0] mem_addr,
  output rsp_t              rsp
);

  // State
  logic [7:0]            count_reg, count_reg_next;
  logic [7:0]            lba_lo, lba_lo_next;
  logic [7:0]            lba_mi, lba_mi_next;
  logic [7:0]            lba_hi, lba_hi_next;
  logic [7:0]            select_reg, select_reg_next;
  logic [7:0]            error_reg, error_reg_next;
  logic                  err_flag, err_flag_next;
  mode_t                 mode, mode_next;
  logic [WORD_IDX_W-1:0] word_index, word_index_next;
  logic [8:0]            sectors_left, sectors_left_next;
  logic [LBA_W-1:0]      xfer_lba, xfer_lba_next;

  // Decode helpers
  logic                  present;
  logic [CAP_W-1:0]      capacity;
  logic [LBA_W-1:0]      cap_wide;
  logic [LBA_W-1:0]      cmd_lba;
  logic [LBA_W-1:0]      lba_inc;
  logic [8:0]            left_dec;
  logic [SIDX_W-1:0]     sector_idx;
  logic [15:0]           id_word;
  logic [7:0]            byte_in;
  logic                  adv;

  assign byte_in  = wdata[7:0];
  assign present  = drive_mask[select_reg[4]];
  assign capacity = (int'(disk_cap) > MAX_SECTORS) ? CAP_W'(MAX_SECTORS) : disk_cap;
  assign cap_wide = LBA_W'(capacity);
  assign cmd_lba  = {select_reg[3:0], lba_hi, lba_mi, lba_lo};
  assign lba_inc  = xfer_lba + 1'b1;
  assign left_dec = sectors_left - 1'b1;

  // Store address: drive bank plus sector, word in the low bits
  assign sector_idx = (select_reg[4] ? SIDX_W'(MAX_SECTORS) : '0) + xfer_lba[SIDX_W-1:0];
  assign mem_addr   = {sector_idx, word_index};

  // Identify page word
  always_comb begin
    id_word = '0;
    if (word_index >= ID_TEXT_FIRST && word_index <= ID_TEXT_LAST) begin
      id_word = ID_SPACES;
    end else if (word_index == ID_CAP_WORD) begin
      id_word = 16'(capacity);
    end
  end

  // Next state and response for the transaction at hand
  always_comb begin
    count_reg_next    = count_reg;
    lba_lo_next       = lba_lo;
    lba_mi_next       = lba_mi;
    lba_hi_next       = lba_hi;
    select_reg_next   = select_reg;
    error_reg_next    = error_reg;
    err_flag_next     = err_flag;
    mode_next         = mode;
    word_index_next   = word_index;
    sectors_left_next = sectors_left;
    xfer_lba_next     = xfer_lba;
    mem_ctrl          = '0;
    rsp               = '0;
    adv               = 1'b0;

    if (req_type) begin
      case (reg_offset)
        OFF_DATA: begin
          if (present && mode == MODE_WRITE) begin
            mem_ctrl.we = fire;
            adv         = 1'b1;
          end
        end
        OFF_COUNT:  count_reg_next  = byte_in;
        OFF_LBA_LO: lba_lo_next     = byte_in;
        OFF_LBA_MI: lba_mi_next     = byte_in;
        OFF_LBA_HI: lba_hi_next     = byte_in;
        OFF_SELECT: select_reg_next = byte_in;
        OFF_STATUS: begin
          if (present) begin
            err_flag_next   = 1'b0;
            error_reg_next  = '0;
            mode_next       = MODE_IDLE;
            word_index_next = '0;
            case (byte_in)
              CMD_IDENTIFY: begin
                mode_next         = MODE_IDENT;
                sectors_left_next = 9'd1;
              end
              CMD_READ, CMD_WRITE: begin
                if (cmd_lba >= cap_wide) begin
                  err_flag_next  = 1'b1;
                  error_reg_next = ERR_RANGE;
                end else begin
                  xfer_lba_next     = cmd_lba;
                  sectors_left_next = (count_reg == '0) ? 9'd256 : {1'b0, count_reg};
                  mode_next         = (byte_in == CMD_READ) ? MODE_READ : MODE_WRITE;
                end
              end
              CMD_FLUSH: ;
              default: begin
                err_flag_next  = 1'b1;
                error_reg_next = ERR_ABORT;
              end
            endcase
          end
        end
        default: ;
      endcase
    end else begin
      case (reg_offset)
        OFF_DATA: begin
          if (present && mode == MODE_IDENT) begin
            rsp.value = id_word;
            adv       = 1'b1;
          end else if (present && mode == MODE_READ) begin
            mem_ctrl.re  = fire;
            rsp.from_mem = 1'b1;
            adv          = 1'b1;
          end
        end
        OFF_ERROR:  rsp.value = {8'h00, error_reg};
        OFF_COUNT:  rsp.value = {8'h00, count_reg};
        OFF_LBA_LO: rsp.value = {8'h00, lba_lo};
        OFF_LBA_MI: rsp.value = {8'h00, lba_mi};
        OFF_LBA_HI: rsp.value = {8'h00, lba_hi};
        OFF_SELECT: rsp.value = {8'h00, select_reg};
        default: begin
          if (present) begin
            rsp.value = {8'h00, ((mode != MODE_IDLE) ? ST_DRQ : 8'h00) |
                                (err_flag ? ST_ERR : 8'h00)};
          end
        end
      endcase
    end

    // Advance the transfer by one word; close or fail at sector ends
    if (adv) begin
      if (word_index == '1) begin
        word_index_next   = '0;
        sectors_left_next = left_dec;
        xfer_lba_next     = lba_inc;
        if (left_dec == '0) begin
          mode_next = MODE_IDLE;
        end else if (mode != MODE_IDENT && lba_inc >= cap_wide) begin
          err_flag_next  = 1'b1;
          error_reg_next = ERR_RANGE;
          mode_next      = MODE_IDLE;
        end
      end else begin
        word_index_next = word_index + 1'b1;
      end
    end
  end

  // Update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg    <= COUNT_RESET;
      lba_lo       <= '0;
      lba_mi       <= '0;
      lba_hi       <= '0;
      select_reg   <= SELECT_RESET;
      error_reg    <= '0;
      err_flag     <= 1'b0;
      mode         <= MODE_IDLE;
      word_index   <= '0;
      sectors_left <= '0;
      xfer_lba     <= '0;
    end else if (fire) begin
      count_reg    <= count_reg_next;
      lba_lo       <= lba_lo_next;
      lba_mi       <= lba_mi_next;
      lba_hi       <= lba_hi_next;
      select_reg   <= select_reg_next;
      error_reg    <= error_reg_next;
      err_flag     <= err_flag_next;
      mode         <= mode_next;
      word_index   <= word_index_next;
      sectors_left <= sectors_left_next;
      xfer_lba     <= xfer_lba_next;
    end
  end

endmodule

>>> sv/ata_pio_task_file_device_core.sv
// Result: a result appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result is taken; the
// sector store port and the output register each take one access per cycle.
// Reset: synchronous, active high; task file and configuration return to
// their defaults at once, the sector store holds undefined data until written.
// ---------------------------------------------------------------------------
// ata_pio_task_file_device_core
// Device side of an ATA channel in PIO mode with an APB configuration port.
// ---------------------------------------------------------------------------
module ata_pio_task_file_device_core import atapio_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Port access request
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [2:0]  reg_offset,
  input  logic [15:0] wdata,
  // Port access result
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] rdata,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ADDR_W = $clog2(2 * MAX_SECTORS) + WORD_IDX_W;

  logic              fire;
  logic [1:0]        drive_mask;
  logic [CAP_W-1:0]  disk_cap;
  mem_ctrl_t         mem_ctrl;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       mem_q;
  rsp_t              rsp_d;
  rsp_t              rsp_q;

  // Accept while the result register is empty or draining
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;

  atapio_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .drive_mask (drive_mask),
    .disk_cap   (disk_cap)
  );

  atapio_tfile #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_tfile (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (req_type),
    .reg_offset (reg_offset),
    .wdata      (wdata),
    .drive_mask (drive_mask),
    .disk_cap   (disk_cap),
    .mem_ctrl   (mem_ctrl),
    .mem_addr   (mem_addr),
    .rsp        (rsp_d)
  );

  atapio_store #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_store (
    .clk   (clk),
    .ctrl  (mem_ctrl),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (mem_q)
  );

  // Result register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Pick the store word or the register value
  assign rdata = rsp_q.from_mem ? mem_q : rsp_q.value;

endmodule

>>> sv/atapio_checker.sv
// ---------------------------------------------------------------------------
// atapio_checker
// Port-level checks of the task file core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atapio_checker import atapio_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic [2:0]  reg_offset,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rdata
);

  logic byte_rd;

  // Accepted read of a byte-wide task file register
  assign byte_rd = req_valid && req_ready && !req_type && reg_offset != OFF_DATA;

  // A write transaction answers zero in the following cycle
  `CHK_NEXT(a_write_zero, req_valid && req_ready && req_type, rsp_valid && rdata == 16'h0000)

  // Byte registers never show an upper byte
  `CHK_NEXT(a_byte_reg, byte_rd, rdata[15:8] == 8'h00)

  // Back-pressure only comes from a waiting result
  `CHK_SAME(a_ready_src, !req_ready, rsp_valid)

  // A stalled result holds
  `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rdata))

endmodule

bind ata_pio_task_file_device_core atapio_checker u_chk (.*);

>>> verif/ata_pio_task_file_device_core_test.sv
// ---------------------------------------------------------------------------
// ata_pio_task_file_device_core_test
// Self-checking bench for the ATA PIO task file device core. A directed table
// covers reset values, error codes and the corner cases of the command set.
// Random command sequences (task file setup, command, data burst) follow.
// Both handshake sides idle at random. Every result is checked in order
// against a shadow model of the task file and the sector store. The drive
// mask and the capacity change between phases over the APB port.
// ---------------------------------------------------------------------------
module ata_pio_task_file_device_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import atapio_pkg::*;

  localparam int  STORE_WORDS        = 2 * MAX_SECTORS_DEF * WORDS_PER_SECTOR;
  localparam int  COUNT_ZERO_SECTORS = 256;
  localparam int  PHASES             = 6;
  localparam int  PHASE_ITEMS        = 200;
  localparam int  SQUEEZE_CYCLES     = 400;
  localparam int  CYCLE_LIMIT        = 1000000;
  localparam int  REPORT_LIMIT       = 10;
  localparam int  N_PLAN             = 26;
  localparam logic ACC_RD            = 1'b0;
  localparam logic ACC_WR            = 1'b1;
  localparam logic [7:0] SEL_DRIVE   = 8'h10;

  typedef struct packed {
    logic        wr;
    logic [2:0]  off;
    logic [15:0] wd;
    logic        typed_in;
    logic [15:0] want;
  } plan_row_t;

  // Ports
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        req_type  = 1'b0;
  logic [2:0]  reg_offset = '0;
  logic [15:0] wdata     = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [15:0] rdata;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow task file, transfer state and configuration
  logic [7:0]  tf_count, tf_lba_lo, tf_lba_mid, tf_lba_hi, tf_select, tf_error;
  logic        tf_err;
  mode_t       xfer_mode;
  int          xfer_word;
  int          xfer_left;
  logic [27:0] xfer_lba;
  logic [1:0]  cfg_present;
  logic [6:0]  cfg_capacity;
  logic [15:0] store_copy [STORE_WORDS];
  bit          store_written [STORE_WORDS];

  // Scoreboard and stimulus bookkeeping
  logic [15:0] rdata_due [$];
  logic [15:0] rdata_want;
  int          mismatches = 0;
  int          stim_count = 0;
  int          send_calm  = 0;
  bit          squeeze_req = 1'b0;
  logic        last_drive = 1'b0;
  logic [27:0] last_lba   = '0;

  plan_row_t plan [N_PLAN] = '{
    // reset values and an idle data read
    '{ACC_RD, OFF_COUNT,  16'h0000, 1'b1, {8'h00, COUNT_RESET}},
    '{ACC_RD, OFF_SELECT, 16'h0000, 1'b1, {8'h00, SELECT_RESET}},
    '{ACC_RD, OFF_DATA,   16'h0000, 1'b1, 16'h0000},
    // features write has no effect
    '{ACC_WR, OFF_ERROR,  16'hFFFF, 1'b1, 16'h0000},
    '{ACC_RD, OFF_ERROR,  16'h0000, 1'b1, 16'h0000},
    // unknown command aborts
    '{ACC_WR, OFF_STATUS, 16'h00FF, 1'b1, 16'h0000},
    '{ACC_RD, OFF_STATUS, 16'h0000, 1'b1, {8'h00, ST_ERR}},
    '{ACC_RD, OFF_ERROR,  16'h0000, 1'b1, {8'h00, ERR_ABORT}},
    // identify clears the error and raises DRQ
    '{ACC_WR, OFF_STATUS, {8'hFF, CMD_IDENTIFY}, 1'b1, 16'h0000},
    '{ACC_RD, OFF_STATUS, 16'h0000, 1'b1, {8'h00, ST_DRQ}},
    '{ACC_RD, OFF_DATA,   16'h0000, 1'b1, 16'h0000},
    // write to the last sector with a count of zero, dropping identify
    '{ACC_WR, OFF_COUNT,  16'hFF00, 1'b1, 16'h0000},
    '{ACC_WR, OFF_LBA_LO, 16'hA53F, 1'b1, 16'h0000},
    '{ACC_WR, OFF_SELECT, 16'h00E0, 1'b1, 16'h0000},
    '{ACC_WR, OFF_STATUS, {8'h00, CMD_WRITE}, 1'b1, 16'h0000},
    '{ACC_WR, OFF_DATA,   16'hFFFF, 1'b1, 16'h0000},
    '{ACC_WR, OFF_DATA,   16'h0000, 1'b1, 16'h0000},
    // data read against a write transfer
    '{ACC_RD, OFF_DATA,   16'h0000, 1'b1, 16'h0000},
    '{ACC_RD, OFF_LBA_LO, 16'h0000, 1'b0, 16'h0000},
    // sector at the capacity is out of range
    '{ACC_WR, OFF_LBA_LO, 16'h0040, 1'b1, 16'h0000},
    '{ACC_WR, OFF_STATUS, {8'h00, CMD_READ}, 1'b1, 16'h0000},
    '{ACC_RD, OFF_ERROR,  16'h0000, 1'b1, {8'h00, ERR_RANGE}},
    '{ACC_WR, OFF_STATUS, {8'h00, CMD_FLUSH}, 1'b1, 16'h0000},
    '{ACC_RD, OFF_STATUS, 16'h0000, 1'b1, 16'h0000},
    // absent slave reads status zero
    '{ACC_WR, OFF_SELECT, 16'h00F0, 1'b1, 16'h0000},
    '{ACC_RD, OFF_STATUS, 16'h0000, 1'b1, 16'h0000}
  };

  ata_pio_task_file_device_core DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .reg_offset (reg_offset),
    .wdata      (wdata),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rdata      (rdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // Shadow model
  // -------------------------------------------------------------------------
  function automatic void clear_shadow();
    tf_count     = COUNT_RESET;
    tf_lba_lo    = '0;
    tf_lba_mid   = '0;
    tf_lba_hi    = '0;
    tf_select    = SELECT_RESET;
    tf_error     = '0;
    tf_err       = 1'b0;
    xfer_mode    = MODE_IDLE;
    xfer_word    = 0;
    xfer_left    = 0;
    xfer_lba     = '0;
    cfg_present  = MASK_RESET;
    cfg_capacity = CAP_RESET;
  endfunction

  function automatic bit drive_on();
    return cfg_present[tf_select[4]];
  endfunction

  // Capacity above the store size acts as the store size
  function automatic int sectors_avail();
    return (cfg_capacity > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : int'(cfg_capacity);
  endfunction

  function automatic int store_index();
    int idx;
    idx = (tf_select[4] ? MAX_SECTORS_DEF : 0) + int'(xfer_lba);
    idx = idx * WORDS_PER_SECTOR + xfer_word;
    return idx % STORE_WORDS;
  endfunction

  function automatic void raise_error(input logic [7:0] code);
    tf_err    = 1'b1;
    tf_error  = code;
    xfer_mode = MODE_IDLE;
  endfunction

  function automatic logic [15:0] identify_word(input int w);
    if (w >= ID_TEXT_FIRST && w <= ID_TEXT_LAST) return ID_SPACES;
    if (w == ID_CAP_WORD) return 16'(sectors_avail());
    return 16'h0000;
  endfunction

  // Advance one word; close or fail the transfer at a sector boundary
  function automatic void step_word();
    xfer_word++;
    if (xfer_word < WORDS_PER_SECTOR) return;
    xfer_word = 0;
    xfer_left--;
    xfer_lba = xfer_lba + 28'd1;
    if (xfer_left == 0) xfer_mode = MODE_IDLE;
    else if (xfer_mode != MODE_IDENT && xfer_lba >= sectors_avail()) raise_error(ERR_RANGE);
  endfunction

  function automatic void start_command(input logic [7:0] cmd);
    logic [27:0] lba;
    if (!drive_on()) return;
    tf_err    = 1'b0;
    tf_error  = '0;
    xfer_mode = MODE_IDLE;
    xfer_word = 0;
    case (cmd)
      CMD_IDENTIFY: begin
        xfer_mode = MODE_IDENT;
        xfer_left = 1;
      end
      CMD_READ, CMD_WRITE: begin
        lba = {tf_select[3:0], tf_lba_hi, tf_lba_mid, tf_lba_lo};
        if (lba >= sectors_avail()) begin
          raise_error(ERR_RANGE);
        end else begin
          xfer_lba  = lba;
          xfer_left = (tf_count == 8'h00) ? COUNT_ZERO_SECTORS : int'(tf_count);
          xfer_mode = (cmd == CMD_READ) ? MODE_READ : MODE_WRITE;
        end
      end
      CMD_FLUSH: ;
      default: raise_error(ERR_ABORT);
    endcase
  endfunction

  function automatic logic [15:0] next_data_word();
    logic [15:0] v;
    if (!drive_on()) return 16'h0000;
    if (xfer_mode == MODE_IDENT) v = identify_word(xfer_word);
    else if (xfer_mode == MODE_READ) v = store_copy[store_index()];
    else return 16'h0000;
    step_word();
    return v;
  endfunction

  // Apply one port access to the shadow state and return its rdata
  function automatic logic [15:0] access_rdata(input logic wr, input logic [2:0] off,
                                               input logic [15:0] wd);
    logic [15:0] r;
    r = 16'h0000;
    if (wr) begin
      case (off)
        OFF_DATA: begin
          if (drive_on() && xfer_mode == MODE_WRITE) begin
            store_copy[store_index()]    = wd;
            store_written[store_index()] = 1'b1;
            step_word();
          end
        end
        OFF_COUNT:  tf_count   = wd[7:0];
        OFF_LBA_LO: tf_lba_lo  = wd[7:0];
        OFF_LBA_MI: tf_lba_mid = wd[7:0];
        OFF_LBA_HI: tf_lba_hi  = wd[7:0];
        OFF_SELECT: tf_select  = wd[7:0];
        OFF_STATUS: start_command(wd[7:0]);
        default: ;
      endcase
    end else begin
      case (off)
        OFF_DATA:   r = next_data_word();
        OFF_ERROR:  r = {8'h00, tf_error};
        OFF_COUNT:  r = {8'h00, tf_count};
        OFF_LBA_LO: r = {8'h00, tf_lba_lo};
        OFF_LBA_MI: r = {8'h00, tf_lba_mid};
        OFF_LBA_HI: r = {8'h00, tf_lba_hi};
        OFF_SELECT: r = {8'h00, tf_select};
        default: begin
          if (drive_on())
            r = {8'h00, ((xfer_mode != MODE_IDLE) ? ST_DRQ : 8'h00) | (tf_err ? ST_ERR : 8'h00)};
        end
      endcase
    end
    return r;
  endfunction

  // True when a data read now would fetch a store word never written
  function automatic bit read_hits_blank();
    return drive_on() && xfer_mode == MODE_READ && !store_written[store_index()];
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (rdata_due.size() == 0) begin
        flag_mismatch("rdata with nothing due", 32'h0, {16'h0, rdata});
      end else begin
        rdata_want = rdata_due.pop_front();
        if (rdata !== rdata_want) flag_mismatch("rdata", {16'h0, rdata_want}, {16'h0, rdata});
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction, then update the shadow model once it is taken
  task automatic send_access(input logic wr, input logic [2:0] off, input logic [15:0] wd,
                             input logic typed_in, input logic [15:0] want);
    int gap;
    logic [15:0] predicted;
    // steer clear of store words that hold nothing yet
    if (!wr && off == OFF_DATA && read_hits_blank()) off = OFF_STATUS;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= wr;
    reg_offset <= off;
    wdata      <= wd;
    do @(posedge clk); while (!req_ready);
    predicted = access_rdata(wr, off, wd);
    rdata_due.push_back(typed_in ? want : predicted);
    if (!(wr && off == OFF_ERROR)) stim_count++;
  endtask

  task automatic noise_access();
    send_access(1'($urandom), 3'($urandom), 16'($urandom), 1'b0, 16'h0000);
  endtask

  // Task file setup, one command, then a burst of data port traffic
  task automatic command_sequence();
    logic [7:0]  cmd;
    logic        drv;
    logic [27:0] lba;
    logic [7:0]  cnt;
    int          burst;
    int          pick;
    int          avail;
    avail = sectors_avail();
    pick  = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_WRITE;
    else if (pick < 65) cmd = CMD_READ;
    else if (pick < 80) cmd = CMD_IDENTIFY;
    else if (pick < 88) cmd = CMD_FLUSH;
    else cmd = 8'($urandom);
    drv = 1'($urandom);
    lba = (avail > 0) ? 28'($urandom_range(0, avail - 1)) : 28'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) lba = 28'($urandom);
    // reads mostly go back to the sector written last
    if (cmd == CMD_READ && $urandom_range(0, 3) != 0) begin
      drv = last_drive;
      lba = last_lba;
    end
    if (cmd == CMD_WRITE) begin
      last_drive = drv;
      last_lba   = lba;
    end
    cnt = 8'($urandom_range(1, 3));
    if ($urandom_range(0, 7) == 0 || (avail <= 2 && $urandom_range(0, 1) == 0)) cnt = 8'h00;
    else if ($urandom_range(0, 9) == 0) cnt = 8'($urandom);

    send_access(ACC_WR, OFF_SELECT, {8'($urandom), 3'($urandom), drv, lba[27:24]}, 1'b0, 16'h0);
    send_access(ACC_WR, OFF_LBA_LO, {8'($urandom), lba[7:0]},   1'b0, 16'h0);
    send_access(ACC_WR, OFF_LBA_MI, {8'($urandom), lba[15:8]},  1'b0, 16'h0);
    send_access(ACC_WR, OFF_LBA_HI, {8'($urandom), lba[23:16]}, 1'b0, 16'h0);
    send_access(ACC_WR, OFF_COUNT,  {8'($urandom), cnt},        1'b0, 16'h0);
    send_access(ACC_WR, OFF_STATUS, {8'($urandom), cmd},        1'b0, 16'h0);

    if (cmd == CMD_IDENTIFY || cmd == CMD_READ || cmd == CMD_WRITE)
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 70);
    else
      burst = $urandom_range(0, 4);
    repeat (burst) begin
      pick = $urandom_range(0, 63);
      if (pick < 2) noise_access();
      else if (pick < 4) send_access(ACC_RD, OFF_STATUS, 16'($urandom), 1'b0, 16'h0);
      // swap drives in the middle of the transfer
      else if (pick == 4) send_access(ACC_WR, OFF_SELECT, {8'($urandom), tf_select ^ SEL_DRIVE},
                                      1'b0, 16'h0);
      else if (cmd == CMD_WRITE) send_access(ACC_WR, OFF_DATA, 16'($urandom), 1'b0, 16'h0);
      else send_access(ACC_RD, OFF_DATA, 16'($urandom), 1'b0, 16'h0);
    end
  endtask

  // Drop valid after the last transaction so it is not taken twice
  task automatic release_request();
    req_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (rdata_due.size() != 0) @(posedge clk);
  endtask

  // APB write followed by a readback; psel stays high for back-to-back use
  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_MASK) cfg_present = value[1:0];
    else cfg_capacity = value[6:0];
    want = (idx == CFG_MASK) ? {30'h0, cfg_present} : {25'h0, cfg_capacity};
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) flag_mismatch("register readback", want, prdata);
  endtask

  task automatic close_config();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls, calm stretches and one long hold-off
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int calm_left;
    calm_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (calm_left > 0) begin
        calm_left--;
        rsp_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rsp_ready <= 1'b1;
        @(posedge clk);
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 100);
      end
    end
  end

  // Hard stop for a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_flow
    logic [1:0] phase_mask [PHASES];
    logic [6:0] phase_cap  [PHASES];
    int         target;
    phase_mask = '{2'd3, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1};
    phase_cap  = '{7'd64, 7'd1, 7'd0, 7'd17, 7'($urandom_range(2, 63)), 7'd64};
    clear_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table at reset configuration
    for (int i = 0; i < N_PLAN; i++)
      send_access(plan[i].wr, plan[i].off, plan[i].wd, plan[i].typed_in, plan[i].want);

    // random phases, each under its own drive mask and capacity
    for (int p = 0; p < PHASES; p++) begin
      release_request();
      wait_for_results();
      write_register(CFG_MASK, {30'h0, phase_mask[p]});
      write_register(CFG_CAP, {25'h0, phase_cap[p]});
      close_config();
      if (p == 0) squeeze_req = 1'b1;
      target = stim_count + PHASE_ITEMS;
      while (stim_count < target) begin
        if ($urandom_range(0, 4) == 0) noise_access();
        else command_sequence();
      end
    end

    // drain and settle
    release_request();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && rdata_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> ata_pio_task_file_device_core.f
+incdir+sv
sv/atapio_pkg.sv
sv/atapio_cfg.sv
sv/atapio_store.sv
sv/atapio_tfile.sv
sv/ata_pio_task_file_device_core.sv
sv/atapio_checker.sv
verif/ata_pio_task_file_device_core_test.sv
